// File: rtl/solar_zenith_pixel_normalizer_defines.svh
// Assertion helpers for the checker file.
// Each macro expects clk and rst in scope.
`ifndef SOLAR_ZENITH_PIXEL_NORMALIZER_DEFINES_SVH
`define SOLAR_ZENITH_PIXEL_NORMALIZER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SZN_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SZN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/szn_pkg.sv
`default_nettype none
package szn_pkg;

  // Geometry and angle precision.
  localparam int MAX_WIDTH = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int ANGLE_BITS = 16;
  localparam int FRAC = ANGLE_BITS - 2;
  localparam int CORDIC_ITERS = (FRAC < 24) ? FRAC : 24;
  localparam int DIV_STEPS = 16;
  localparam int CNT_W = (CORDIC_ITERS > DIV_STEPS) ? $clog2(CORDIC_ITERS) : $clog2(DIV_STEPS);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CMP_W = (COL_W + 1 > 13) ? COL_W + 1 : 13;
  localparam int ROWC_W = ROW_W + 1;

  // Datapath widths.
  localparam int MX_W = 21 + COL_W + 2;
  localparam int MY_W = 21 + ROW_W + 2;
  localparam int XY_W = ((MX_W > MY_W) ? MX_W : MY_W) + 1;
  localparam int CW = XY_W + 6;
  localparam int ZW = FRAC + 4;
  localparam int H_W = 37;
  localparam int PL_W = ZW + 18;
  localparam int LON_SH_L = (FRAC <= 14) ? 14 - FRAC : 0;
  localparam int LON_SH_R = (FRAC > 14) ? FRAC - 14 : 0;
  localparam int LT_W = PL_W + LON_SH_L;
  localparam int CZ_W = 35;
  localparam int R_W = CZ_W + 1;
  localparam int CLIP_W = 25;
  localparam int CFG_W = 21;
  localparam int CFG_IDX_W = 3;

  // Q2.30 constants, with the Q16 longitude factor and the clip ceiling.
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint NOON_Q30 = 64'sd3373267314;
  localparam longint MINUTE_Q30 = 64'sd4685093;
  localparam longint LON_HOUR_Q16 = 64'sd65569;
  localparam longint INV_GAIN_Q30 = 64'sd652032875;
  localparam longint POLAR_DIST_K = 64'sd40138616;
  localparam logic [CLIP_W-1:0] CLIP_MAX = {CLIP_W{1'b1}};

  function automatic longint q30_to_f(input longint v);
    return (v + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  function automatic longint atan_q30(input int i);
    longint r;
    case (i)
      0: r = 843314857;
      1: r = 497837830;
      2: r = 263043837;
      3: r = 133525159;
      4: r = 67021687;
      5: r = 33543516;
      6: r = 16775851;
      7: r = 8388437;
      8: r = 4194283;
      9: r = 2097149;
      10: r = 1048576;
      11: r = 524288;
      12: r = 262144;
      13: r = 131072;
      14: r = 65536;
      15: r = 32768;
      16: r = 16384;
      17: r = 8192;
      18: r = 4096;
      19: r = 2048;
      20: r = 1024;
      21: r = 512;
      22: r = 256;
      23: r = 128;
      default: r = 0;
    endcase
    return r;
  endfunction

  function automatic longint atan_f(input int i);
    return q30_to_f(atan_q30(i));
  endfunction

  localparam longint PI_F = q30_to_f(PI_Q30);
  localparam longint HALF_PI_F = q30_to_f(HALF_PI_Q30);

  // Round a Q2.30 CORDIC output to Q1.15 with saturation.
  function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0] r;
    r = ($signed({v[CW-1], v}) + $signed((CW + 1)'(16384))) >>> 15;
    if (r > $signed((CW + 1)'(32767))) return 16'sh7FFF;
    if (r < -$signed((CW + 1)'(32768))) return -16'sh8000;
    return 16'(r);
  endfunction

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_X, REG_STEP_Y, REG_ORIGIN_X, REG_ORIGIN_Y,
    REG_ROW_WIDTH, REG_GMT_MINUTES, REG_SIN_DECL, REG_COS_DECL
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_POS, OP_V1_INIT, OP_V2_INIT, OP_LAT_INIT,
    OP_CORDIC_STEP, OP_H_MUL, OP_H_SUM, OP_H_MOD, OP_H_FOLD1, OP_H_FOLD2,
    OP_H_INIT, OP_CZ_Q, OP_CZ_M1, OP_CZ_M2, OP_CZ_SUM, OP_DIV_INIT,
    OP_DIV_STEP, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic [CNT_W-1:0] step;
  } szn_cmd_t;

  typedef struct packed {
    logic pole;
  } szn_stat_t;

endpackage
`default_nettype wire

// File: rtl/szn_in_if.sv
`default_nettype none
interface szn_in_if;
  logic valid;
  logic ready;
  logic frame_start;
  logic [15:0] ch0_in;
  logic [15:0] ch1_in;

  modport source (output valid, output frame_start, output ch0_in, output ch1_in,
                  input ready);
  modport sink (input valid, input frame_start, input ch0_in, input ch1_in,
                output ready);
endinterface
`default_nettype wire

// File: rtl/szn_out_if.sv
`default_nettype none
interface szn_out_if;
  logic valid;
  logic ready;
  logic [15:0] ch0_out;
  logic [15:0] ch1_out;
  logic ch0_clipped;
  logic ch1_clipped;
  logic [24:0] ch0_clip_total;
  logic [24:0] ch1_clip_total;

  modport source (output valid, output ch0_out, output ch1_out, output ch0_clipped,
                  output ch1_clipped, output ch0_clip_total, output ch1_clip_total,
                  input ready);
  modport sink (input valid, input ch0_out, input ch1_out, input ch0_clipped,
                input ch1_clipped, input ch0_clip_total, input ch1_clip_total,
                output ready);
endinterface
`default_nettype wire

// File: rtl/szn_ctrl.sv
`default_nettype none
module szn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  szn_pkg::szn_stat_t  stat,
  output szn_pkg::szn_cmd_t   cmd
);
  import szn_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_POS, ST_V1_INIT, ST_V1_RUN, ST_V2_INIT, ST_V2_RUN,
    ST_LAT_INIT, ST_LAT_RUN, ST_H_MUL, ST_H_SUM, ST_H_MOD, ST_H_FOLD1,
    ST_H_FOLD2, ST_H_INIT, ST_H_RUN, ST_CZ_Q, ST_CZ_M1, ST_CZ_M2,
    ST_CZ_SUM, ST_DIV_INIT, ST_DIV_RUN, ST_FINISH
  } state_t;

  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_ITERS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic finish_go;

  assign finish_go = !out_valid || out_ready;

  always_comb begin
    cmd.step = cnt;
    case (state)
      ST_IDLE:     cmd.op = (in_valid && in_ready) ? OP_LOAD : OP_NONE;
      ST_POS:      cmd.op = OP_POS;
      ST_V1_INIT:  cmd.op = OP_V1_INIT;
      ST_V1_RUN:   cmd.op = OP_CORDIC_STEP;
      ST_V2_INIT:  cmd.op = OP_V2_INIT;
      ST_V2_RUN:   cmd.op = OP_CORDIC_STEP;
      ST_LAT_INIT: cmd.op = OP_LAT_INIT;
      ST_LAT_RUN:  cmd.op = OP_CORDIC_STEP;
      ST_H_MUL:    cmd.op = OP_H_MUL;
      ST_H_SUM:    cmd.op = OP_H_SUM;
      ST_H_MOD:    cmd.op = OP_H_MOD;
      ST_H_FOLD1:  cmd.op = OP_H_FOLD1;
      ST_H_FOLD2:  cmd.op = OP_H_FOLD2;
      ST_H_INIT:   cmd.op = OP_H_INIT;
      ST_H_RUN:    cmd.op = OP_CORDIC_STEP;
      ST_CZ_Q:     cmd.op = OP_CZ_Q;
      ST_CZ_M1:    cmd.op = OP_CZ_M1;
      ST_CZ_M2:    cmd.op = OP_CZ_M2;
      ST_CZ_SUM:   cmd.op = OP_CZ_SUM;
      ST_DIV_INIT: cmd.op = OP_DIV_INIT;
      ST_DIV_RUN:  cmd.op = OP_DIV_STEP;
      ST_FINISH:   cmd.op = finish_go ? OP_FINISH : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      in_ready <= 1'b0;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      // The finish state sets the flag itself, so the taken result is cleared elsewhere only.
      if (out_valid && out_ready && state != ST_FINISH) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            state <= ST_POS;
          end else begin
            in_ready <= 1'b1;
          end
        end
        ST_POS: state <= ST_V1_INIT;
        ST_V1_INIT: begin
          cnt <= '0;
          state <= stat.pole ? ST_V2_INIT : ST_V1_RUN;
        end
        ST_V1_RUN: begin
          if (cnt == CORDIC_LAST) begin
            cnt <= '0;
            state <= ST_V2_INIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_V2_INIT: begin
          cnt <= '0;
          state <= ST_V2_RUN;
        end
        ST_V2_RUN: begin
          if (cnt == CORDIC_LAST) begin
            cnt <= '0;
            state <= ST_LAT_INIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_LAT_INIT: begin
          cnt <= '0;
          state <= ST_LAT_RUN;
        end
        ST_LAT_RUN: begin
          if (cnt == CORDIC_LAST) begin
            cnt <= '0;
            state <= ST_H_MUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_H_MUL:   state <= ST_H_SUM;
        ST_H_SUM:   state <= ST_H_MOD;
        ST_H_MOD:   state <= ST_H_FOLD1;
        ST_H_FOLD1: state <= ST_H_FOLD2;
        ST_H_FOLD2: state <= ST_H_INIT;
        ST_H_INIT: begin
          cnt <= '0;
          state <= ST_H_RUN;
        end
        ST_H_RUN: begin
          if (cnt == CORDIC_LAST) begin
            cnt <= '0;
            state <= ST_CZ_Q;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_CZ_Q:   state <= ST_CZ_M1;
        ST_CZ_M1:  state <= ST_CZ_M2;
        ST_CZ_M2:  state <= ST_CZ_SUM;
        ST_CZ_SUM: state <= ST_DIV_INIT;
        ST_DIV_INIT: begin
          cnt <= '0;
          state <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          if (cnt == DIV_LAST) begin
            cnt <= '0;
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/szn_dp.sv
`default_nettype none
module szn_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [szn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [szn_pkg::CFG_W-1:0]        cfg_data,
  input  szn_pkg::szn_cmd_t                cmd,
  output szn_pkg::szn_stat_t               stat,
  input  logic                             frame_start,
  input  logic [15:0]                      ch0_in,
  input  logic [15:0]                      ch1_in,
  output logic [15:0]                      ch0_out,
  output logic [15:0]                      ch1_out,
  output logic                             ch0_clipped,
  output logic                             ch1_clipped,
  output logic [szn_pkg::CLIP_W-1:0]       ch0_clip_total,
  output logic [szn_pkg::CLIP_W-1:0]       ch1_clip_total
);
  import szn_pkg::*;

  // Configuration registers.
  logic signed [20:0] step_x;
  logic [19:0] step_y;
  logic signed [19:0] origin_x;
  logic signed [19:0] origin_y;
  logic [12:0] row_width;
  logic [10:0] gmt_minutes;
  logic signed [15:0] sin_decl;
  logic signed [15:0] cos_decl;

  // Frame state.
  logic [COL_W-1:0] column_index;
  logic [ROW_W-1:0] row_index;
  logic [CLIP_W-1:0] clip_count_zero;
  logic [CLIP_W-1:0] clip_count_one;

  // Working registers.
  logic [15:0] ch0_q, ch1_q;
  logic signed [XY_W-1:0] pos_x, pos_y;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic vec_mode;
  logic signed [ZW-1:0] lon;
  logic signed [15:0] cl, sl;
  logic [33:0] p_min;
  logic signed [PL_W-1:0] p_lon;
  logic [H_W-1:0] hang;
  logic h_neg;
  logic signed [16:0] chz;
  logic signed [32:0] m1;
  logic signed [33:0] m2;
  logic signed [31:0] m3;
  logic signed [CZ_W-1:0] cz_val;
  logic [R_W-1:0] rem0, rem1;
  logic [15:0] quo0, quo1;
  logic sat0, sat1, zero0, zero1;

  // Combinational helpers.
  logic signed [MX_W-1:0] mul_x;
  logic signed [MY_W-1:0] mul_y;
  logic signed [CW-1:0] v1_x, v1_y;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  logic up;
  logic signed [LT_W-1:0] lon_term;
  logic signed [H_W-1:0] h_sum;
  logic signed [15:0] q_cx;
  logic signed [17:0] m1s;
  logic [CZ_W-2:0] divisor;
  logic [49:0] lim;
  logic over0, over1;
  logic [R_W-1:0] r0s, r1s;
  logic [CMP_W-1:0] width_eff, col_inc;
  logic [ROWC_W-1:0] row_inc;
  logic [CLIP_W-1:0] clip0_next, clip1_next;

  assign stat.pole = (pos_x == '0) && (pos_y == '0);

  always_comb begin
    mul_x = step_x * $signed({1'b0, column_index, 1'b1});
    mul_y = $signed({1'b0, step_y}) * $signed({1'b0, row_index, 1'b1});
    v1_x = -CW'(pos_y);
    v1_y = CW'(pos_x);
    dx = cy >>> cmd.step;
    dy = cx >>> cmd.step;
    at = ZW'(atan_f(int'(cmd.step)));
    up = vec_mode ? cy[CW-1] : !cz[ZW-1];
    lon_term = (LT_W'(p_lon) <<< LON_SH_L) >>> LON_SH_R;
    h_sum = $signed(H_W'(p_min)) + H_W'(lon_term) - H_W'(NOON_Q30);
    q_cx = to_q15(cx);
    m1s = 18'(m1 >>> 15);
    divisor = cz_val[CZ_W-2:0];
    lim = {divisor, 16'b0} - 50'(divisor);
    over0 = (cz_val == '0) ? (ch0_q != '0) : (50'({ch0_q, 30'b0}) > lim);
    over1 = (cz_val == '0) ? (ch1_q != '0) : (50'({ch1_q, 30'b0}) > lim);
    r0s = {rem0[R_W-2:0], 1'b0};
    r1s = {rem1[R_W-2:0], 1'b0};
    width_eff = (row_width == '0 || CMP_W'(row_width) > CMP_W'(MAX_WIDTH))
                ? CMP_W'(MAX_WIDTH) : CMP_W'(row_width);
    col_inc = CMP_W'(column_index) + 1'b1;
    row_inc = ROWC_W'(row_index) + 1'b1;
    clip0_next = (sat0 && clip_count_zero != CLIP_MAX) ? clip_count_zero + 1'b1
                                                       : clip_count_zero;
    clip1_next = (sat1 && clip_count_one != CLIP_MAX) ? clip_count_one + 1'b1
                                                      : clip_count_one;
  end

  // Configuration and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_x <= 21'sd1024;
      step_y <= 20'd1024;
      origin_x <= '0;
      origin_y <= '0;
      row_width <= 13'd4096;
      gmt_minutes <= 11'd720;
      sin_decl <= '0;
      cos_decl <= 16'sd32767;
      column_index <= '0;
      row_index <= '0;
      clip_count_zero <= '0;
      clip_count_one <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_STEP_X:      step_x <= cfg_data[20:0];
          REG_STEP_Y:      step_y <= cfg_data[19:0];
          REG_ORIGIN_X:    origin_x <= cfg_data[19:0];
          REG_ORIGIN_Y:    origin_y <= cfg_data[19:0];
          REG_ROW_WIDTH:   row_width <= cfg_data[12:0];
          REG_GMT_MINUTES: gmt_minutes <= cfg_data[10:0];
          REG_SIN_DECL:    sin_decl <= cfg_data[15:0];
          REG_COS_DECL:    cos_decl <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD && frame_start) begin
        column_index <= '0;
        row_index <= '0;
        clip_count_zero <= '0;
        clip_count_one <= '0;
      end
      if (cmd.op == OP_FINISH) begin
        clip_count_zero <= clip0_next;
        clip_count_one <= clip1_next;
        if (col_inc >= width_eff) begin
          column_index <= '0;
          row_index <= (row_inc >= ROWC_W'(MAX_HEIGHT)) ? '0 : ROW_W'(row_inc);
        end else begin
          column_index <= COL_W'(col_inc);
        end
      end
    end
  end

  // Arithmetic sequence.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        ch0_q <= ch0_in;
        ch1_q <= ch1_in;
      end
      OP_POS: begin
        pos_x <= (XY_W'(origin_x) <<< 7) + XY_W'(mul_x);
        pos_y <= (XY_W'(origin_y) <<< 7) - XY_W'(mul_y);
      end
      OP_V1_INIT: begin
        vec_mode <= 1'b1;
        if (stat.pole) begin
          cx <= '0;
          cy <= '0;
          cz <= '0;
        end else if (v1_x[CW-1]) begin
          cz <= v1_y[CW-1] ? -ZW'(PI_F) : ZW'(PI_F);
          cx <= -v1_x;
          cy <= -v1_y;
        end else begin
          cz <= '0;
          cx <= v1_x;
          cy <= v1_y;
        end
      end
      OP_V2_INIT: begin
        lon <= cz;
        vec_mode <= 1'b1;
        cx <= CW'(POLAR_DIST_K);
        cy <= cx;
        cz <= '0;
      end
      OP_LAT_INIT: begin
        vec_mode <= 1'b0;
        cx <= CW'(INV_GAIN_Q30);
        cy <= '0;
        cz <= ZW'(HALF_PI_F) - (cz <<< 1);
      end
      OP_CORDIC_STEP: begin
        if (up) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - at;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + at;
        end
      end
      OP_H_MUL: begin
        cl <= to_q15(cx);
        sl <= to_q15(cy);
        p_min <= 34'(gmt_minutes) * 34'(MINUTE_Q30);
        p_lon <= lon * $signed(18'(LON_HOUR_Q16));
      end
      OP_H_SUM: hang <= h_sum[H_W-1] ? H_W'(-h_sum) : H_W'(h_sum);
      OP_H_MOD: begin
        if (hang >= H_W'(TWO_PI_Q30)) hang <= hang - H_W'(TWO_PI_Q30);
      end
      OP_H_FOLD1: begin
        if (hang > H_W'(PI_Q30)) hang <= H_W'(TWO_PI_Q30) - hang;
      end
      OP_H_FOLD2: begin
        h_neg <= hang > H_W'(HALF_PI_Q30);
        if (hang > H_W'(HALF_PI_Q30)) hang <= H_W'(PI_Q30) - hang;
      end
      OP_H_INIT: begin
        vec_mode <= 1'b0;
        cx <= CW'(INV_GAIN_Q30);
        cy <= '0;
        cz <= $signed(ZW'(hang >> (30 - FRAC)));
      end
      OP_CZ_Q:   chz <= h_neg ? -17'(q_cx) : 17'(q_cx);
      OP_CZ_M1:  m1 <= cl * chz;
      OP_CZ_M2: begin
        m2 <= m1s * cos_decl;
        m3 <= sl * sin_decl;
      end
      OP_CZ_SUM: cz_val <= CZ_W'(m2) + CZ_W'(m3);
      OP_DIV_INIT: begin
        sat0 <= !cz_val[CZ_W-1] && over0;
        sat1 <= !cz_val[CZ_W-1] && over1;
        zero0 <= cz_val[CZ_W-1] || (cz_val == '0);
        zero1 <= cz_val[CZ_W-1] || (cz_val == '0);
        rem0 <= R_W'({ch0_q, 14'b0});
        rem1 <= R_W'({ch1_q, 14'b0});
        quo0 <= '0;
        quo1 <= '0;
      end
      OP_DIV_STEP: begin
        if (r0s >= R_W'(divisor)) begin
          rem0 <= r0s - R_W'(divisor);
          quo0 <= {quo0[14:0], 1'b1};
        end else begin
          rem0 <= r0s;
          quo0 <= {quo0[14:0], 1'b0};
        end
        if (r1s >= R_W'(divisor)) begin
          rem1 <= r1s - R_W'(divisor);
          quo1 <= {quo1[14:0], 1'b1};
        end else begin
          rem1 <= r1s;
          quo1 <= {quo1[14:0], 1'b0};
        end
      end
      OP_FINISH: begin
        ch0_out <= sat0 ? 16'hFFFF : (zero0 ? 16'h0000 : quo0);
        ch1_out <= sat1 ? 16'hFFFF : (zero1 ? 16'h0000 : quo1);
        ch0_clipped <= sat0;
        ch1_clipped <= sat1;
        ch0_clip_total <= clip0_next;
        ch1_clip_total <= clip1_next;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/solar_zenith_pixel_normalizer.sv
// Channel   Dir  Handshake     Payload
// pix_in    in   valid/ready   frame_start, ch0_in, ch1_in
// pix_out   out  valid/ready   ch0_out, ch1_out, ch0/ch1_clipped, ch0/ch1_clip_total
// cfg       in   cfg_we        cfg_index, cfg_data
//
// The block takes a new item only once the current one has finished. The shared CORDIC
// unit runs four 14-step passes (three for the pole pixel) and the divider 16 steps.
// Reset is synchronous on rst; it clears control and frame state and loads configuration
// defaults. A result that is not taken stalls the block only at the end of the next item.
`default_nettype none
module solar_zenith_pixel_normalizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [szn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [szn_pkg::CFG_W-1:0]     cfg_data,
  szn_in_if.sink                        pix_in,
  szn_out_if.source                     pix_out
);
  import szn_pkg::*;

  // Command and status between the sequencer and the arithmetic.
  szn_cmd_t cmd;
  szn_stat_t stat;
  logic in_ready;
  logic out_valid;

  // The controller walks one item through position, two vectoring passes (longitude
  // and radius, then latitude), two rotation passes (latitude and hour angle), the
  // zenith cosine products and the two parallel restoring dividers.
  szn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (pix_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the frame counters, the CORDIC unit, the
  // divider and the output register, so a result waits there while the next item runs.
  szn_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .frame_start    (pix_in.frame_start),
    .ch0_in         (pix_in.ch0_in),
    .ch1_in         (pix_in.ch1_in),
    .ch0_out        (pix_out.ch0_out),
    .ch1_out        (pix_out.ch1_out),
    .ch0_clipped    (pix_out.ch0_clipped),
    .ch1_clipped    (pix_out.ch1_clipped),
    .ch0_clip_total (pix_out.ch0_clip_total),
    .ch1_clip_total (pix_out.ch1_clip_total)
  );

  assign pix_in.ready = in_ready;
  assign pix_out.valid = out_valid;

endmodule
`default_nettype wire

// File: rtl/szn_checker.sv
`default_nettype none
`include "solar_zenith_pixel_normalizer_defines.svh"
module szn_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] ch0_out,
  input logic [15:0] ch1_out,
  input logic        ch0_clipped,
  input logic        ch1_clipped,
  input logic [24:0] ch0_clip_total,
  input logic [24:0] ch1_clip_total
);

  `SZN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ch0_out) && $stable(ch1_out) && $stable(ch0_clip_total), "stalled item changed")
  `SZN_ASSERT_SAME(a_clip0, out_valid && ch0_clipped, ch0_out == 16'hFFFF && ch0_clip_total != 25'd0, "channel zero clip inconsistent")
  `SZN_ASSERT_SAME(a_clip1, out_valid && ch1_clipped, ch1_out == 16'hFFFF && ch1_clip_total != 25'd0, "channel one clip inconsistent")
  `SZN_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "item accepted while busy")

endmodule

bind solar_zenith_pixel_normalizer szn_checker u_szn_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (pix_in.valid),
  .in_ready       (pix_in.ready),
  .out_valid      (pix_out.valid),
  .out_ready      (pix_out.ready),
  .ch0_out        (pix_out.ch0_out),
  .ch1_out        (pix_out.ch1_out),
  .ch0_clipped    (pix_out.ch0_clipped),
  .ch1_clipped    (pix_out.ch1_clipped),
  .ch0_clip_total (pix_out.ch0_clip_total),
  .ch1_clip_total (pix_out.ch1_clip_total)
);
`default_nettype wire
